// File: hdl/lgsc_pkg.sv
`timescale 1ns / 1ps

package lgsc_pkg;

    localparam int CAPACITY = 64;
    localparam int POS_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CODE_W   = 16;
    localparam int ADV_W    = 8;
    localparam int TILE_W   = 5;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [CNT_W-1:0] t_cnt;

    // one line of the recency list; position 0 is most recently used
    typedef struct packed {
        logic [CODE_W-1:0] code;
        t_pos              slot;
        logic [ADV_W-1:0]  adv;
    } t_entry;

    typedef struct packed {
        logic   re;
        t_pos   raddr;
        logic   we;
        t_pos   waddr;
        t_entry wdata;
    } t_mem_req;

    typedef struct packed {
        logic              found;
        logic              was_hit;
        logic [TILE_W-1:0] tile_index;
        logic              palette_plane;
        logic [ADV_W-1:0]  advance_out;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT,
        ST_FRONT,
        ST_EMIT
    } t_state;

endpackage

// File: hdl/lgsc_if.sv
`timescale 1ns / 1ps

interface lgsc_req_if;
    logic                     valid;
    logic                     ready;
    logic [lgsc_pkg::CODE_W-1:0] char_code;
    logic                     glyph_available;
    logic [lgsc_pkg::ADV_W-1:0]  glyph_advance;

    modport source (output valid, char_code, glyph_available, glyph_advance, input ready);
    modport sink   (input valid, char_code, glyph_available, glyph_advance, output ready);
endinterface

interface lgsc_rsp_if;
    logic                     valid;
    logic                     ready;
    logic                     found;
    logic                     was_hit;
    logic [lgsc_pkg::TILE_W-1:0] tile_index;
    logic                     palette_plane;
    logic [lgsc_pkg::ADV_W-1:0]  advance_out;

    modport source (output valid, found, was_hit, tile_index, palette_plane, advance_out,
                    input ready);
    modport sink   (input valid, found, was_hit, tile_index, palette_plane, advance_out,
                    output ready);
endinterface

interface lgsc_cfg_if;
    logic valid;
    logic ready;
    logic glyph_source_present;

    modport source (output valid, glyph_source_present, input ready);
    modport sink   (input valid, glyph_source_present, output ready);
endinterface

// File: hdl/lru_glyph_slot_cache_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                                              Handshake
// i_req     in   char_code[15:0] glyph_available glyph_advance[7:0]   valid/ready
// o_rsp     out  found was_hit tile_index[4:0] palette_plane           valid/ready
//                advance_out[7:0]
// i_cfg     in   glyph_source_present                                 valid/ready
//
// One request at a time. A hit scans up to its entry, shifts and writes it to the front; a loaded
// miss scans all valid entries, then shifts and writes to the front; a failed miss scans and emits. The list
// memory gives one entry read per cycle while scanning, one moved per cycle to front.
// Reset (sync, active low) empties the list and clears the source flag; no
// clearing pass, entries at or past the fill count are never read.
// A stalled o_rsp holds the sequencer in its result stage; i_cfg is always ready.
module lru_glyph_slot_cache_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lgsc_req_if.sink    i_req,
    lgsc_rsp_if.source  o_rsp,
    lgsc_cfg_if.sink    i_cfg
);

    logic               r_src_present;
    lgsc_pkg::t_mem_req mem_req;
    lgsc_pkg::t_entry   mem_rdata;

    // configuration: glyph source installed flag
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_present <= 1'b0;
        end else if (i_cfg.valid) begin
            r_src_present <= i_cfg.glyph_source_present;
        end
    end

    // recency list: position 0 most recent; each line carries its fixed slot
    lgsc_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // scan / fill / shift sequencer with result register
    lgsc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_src_present (r_src_present),
        .i_req         (i_req),
        .o_rsp         (o_rsp),
        .o_mem_req     (mem_req),
        .i_mem_rdata   (mem_rdata)
    );

endmodule

// File: hdl/lgsc_mem.sv
`timescale 1ns / 1ps

// recency list store: one write port, one read port, registered read data
module lgsc_mem (
    input  logic                 i_clk,
    input  lgsc_pkg::t_mem_req   i_req,
    output lgsc_pkg::t_entry     o_rdata
);

    lgsc_pkg::t_entry mem [lgsc_pkg::CAPACITY];
    lgsc_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/lgsc_ctrl.sv
`timescale 1ns / 1ps

// lookup sequencer: scan, fill decision, move-to-front shift, result register
module lgsc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_src_present,
    lgsc_req_if.sink             i_req,
    lgsc_rsp_if.source           o_rsp,
    output lgsc_pkg::t_mem_req   o_mem_req,
    input  lgsc_pkg::t_entry     i_mem_rdata
);

    lgsc_pkg::t_state r_state, n_state;
    lgsc_pkg::t_cnt   r_count, n_count;
    lgsc_pkg::t_pos   r_pos, n_pos;
    lgsc_pkg::t_pos   r_last_slot, n_last_slot;
    lgsc_pkg::t_entry r_ent, n_ent;
    lgsc_pkg::t_rsp   r_rsp, n_rsp;
    logic             r_rsp_valid, n_rsp_valid;
    logic [lgsc_pkg::CODE_W-1:0] r_code, n_code;
    logic [lgsc_pkg::ADV_W-1:0]  r_adv, n_adv;
    logic             r_avail, n_avail;
    logic             r_found, n_found;
    logic             r_hit, n_hit;

    logic             full;
    lgsc_pkg::t_pos   fill_pos;

    assign full     = (r_count == lgsc_pkg::CNT_W'(lgsc_pkg::CAPACITY));
    assign fill_pos = full ? lgsc_pkg::POS_W'(lgsc_pkg::CAPACITY - 1)
                           : r_count[lgsc_pkg::POS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lgsc_pkg::ST_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_last_slot <= n_last_slot;
        r_ent       <= n_ent;
        r_rsp       <= n_rsp;
        r_code      <= n_code;
        r_adv       <= n_adv;
        r_avail     <= n_avail;
        r_found     <= n_found;
        r_hit       <= n_hit;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_last_slot = r_last_slot;
        n_ent       = r_ent;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid;
        n_code      = r_code;
        n_adv       = r_adv;
        n_avail     = r_avail;
        n_found     = r_found;
        n_hit       = r_hit;
        o_mem_req   = '0;
        i_req.ready = 1'b0;

        if (r_rsp_valid && o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end

        unique case (r_state)
            lgsc_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_code  = i_req.char_code;
                    n_avail = i_req.glyph_available;
                    n_adv   = i_req.glyph_advance;
                    n_pos   = '0;
                    if (r_count == '0) begin
                        n_state = lgsc_pkg::ST_DECIDE;
                    end else begin
                        o_mem_req.re    = 1'b1;
                        o_mem_req.raddr = '0;
                        n_state         = lgsc_pkg::ST_SCAN;
                    end
                end
            end
            lgsc_pkg::ST_SCAN: begin
                // read data belongs to position r_pos
                n_last_slot = i_mem_rdata.slot;
                if (i_mem_rdata.code == r_code) begin
                    n_ent   = i_mem_rdata;
                    n_found = 1'b1;
                    n_hit   = 1'b1;
                    if (r_pos == '0) begin
                        n_state = lgsc_pkg::ST_FRONT;
                    end else begin
                        o_mem_req.re    = 1'b1;
                        o_mem_req.raddr = r_pos - 1'b1;
                        n_state         = lgsc_pkg::ST_SHIFT;
                    end
                end else if (lgsc_pkg::CNT_W'(r_pos) + 1'b1 == r_count) begin
                    n_state = lgsc_pkg::ST_DECIDE;
                end else begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = r_pos + 1'b1;
                    n_pos           = r_pos + 1'b1;
                end
            end
            lgsc_pkg::ST_DECIDE: begin
                n_hit = 1'b0;
                if (!i_src_present || !r_avail) begin
                    n_found = 1'b0;
                    n_state = lgsc_pkg::ST_EMIT;
                end else begin
                    // a new entry takes the slot numbered by the fill count; when full the
                    // last scanned entry (LRU) gives up its slot
                    n_found    = 1'b1;
                    n_ent.code = r_code;
                    n_ent.adv  = r_adv;
                    n_ent.slot = full ? r_last_slot : r_count[lgsc_pkg::POS_W-1:0];
                    n_pos      = fill_pos;
                    if (!full) begin
                        n_count = r_count + 1'b1;
                    end
                    if (fill_pos == '0) begin
                        n_state = lgsc_pkg::ST_FRONT;
                    end else begin
                        o_mem_req.re    = 1'b1;
                        o_mem_req.raddr = fill_pos - 1'b1;
                        n_state         = lgsc_pkg::ST_SHIFT;
                    end
                end
            end
            lgsc_pkg::ST_SHIFT: begin
                // mem[r_pos] <= mem[r_pos-1], next read two below
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_pos;
                o_mem_req.wdata = i_mem_rdata;
                if (r_pos == lgsc_pkg::POS_W'(1)) begin
                    n_state = lgsc_pkg::ST_FRONT;
                end else begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = r_pos - lgsc_pkg::POS_W'(2);
                    n_pos           = r_pos - 1'b1;
                end
            end
            lgsc_pkg::ST_FRONT: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = '0;
                o_mem_req.wdata = r_ent;
                n_state         = lgsc_pkg::ST_EMIT;
            end
            lgsc_pkg::ST_EMIT: begin
                if (!r_rsp_valid || o_rsp.ready) begin
                    n_rsp_valid         = 1'b1;
                    n_rsp.found         = r_found;
                    n_rsp.was_hit       = r_found & r_hit;
                    n_rsp.tile_index    = r_found ? lgsc_pkg::TILE_W'(r_ent.slot >> 1) : '0;
                    n_rsp.palette_plane = r_found & r_ent.slot[0];
                    n_rsp.advance_out   = r_found ? r_ent.adv : '0;
                    n_state             = lgsc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lgsc_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_rsp.valid         = r_rsp_valid;
    assign o_rsp.found         = r_rsp.found;
    assign o_rsp.was_hit       = r_rsp.was_hit;
    assign o_rsp.tile_index    = r_rsp.tile_index;
    assign o_rsp.palette_plane = r_rsp.palette_plane;
    assign o_rsp.advance_out   = r_rsp.advance_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lgsc_pkg::CNT_W'(lgsc_pkg::CAPACITY))
        else $error("fill count beyond capacity");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.we && o_mem_req.re |-> o_mem_req.waddr != o_mem_req.raddr)
        else $error("shift reads the entry it writes");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lgsc_pkg::ST_SCAN |-> lgsc_pkg::CNT_W'(r_pos) < r_count)
        else $error("scan past the valid entries");

    a_fill_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_rsp_valid && !r_rsp_valid && n_rsp.found && !n_rsp.was_hit |-> r_count != '0)
        else $error("loaded glyph without a counted entry");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> r_state != lgsc_pkg::ST_IDLE)
        else $error("request accepted but sequencer idle");

endmodule
